FILE: sv/rde_pkg.sv
package rde_pkg;

    localparam int FUNC_W = 2;
    localparam int KIND_W = 2;
    localparam int DATA_W = 16;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam func_t FUNC_LOAD    = 2'd0;
    localparam func_t FUNC_REVERSE = 2'd1;
    localparam func_t FUNC_DELETE  = 2'd2;
    localparam func_t FUNC_FINISH  = 2'd3;

    localparam kind_t KIND_VALUE = 2'd0;
    localparam kind_t KIND_ERROR = 2'd1;
    localparam kind_t KIND_EMPTY = 2'd2;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] value;
        logic              last;
    } out_item_t;

endpackage

FILE: sv/rde_ram.sv
module rde_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/rde_outq.sv
module rde_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rde_pkg::out_item_t push_item,
    output logic              m_valid,
    input  logic              m_ready,
    output rde_pkg::out_item_t m_item,
    output logic [1:0]        level
);

    logic [1:0]         cnt_reg, cnt_next;
    rde_pkg::out_item_t slot0_reg, slot0_next;
    rde_pkg::out_item_t slot1_reg, slot1_next;
    logic               pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_item  = slot0_reg;
    assign pop     = m_valid && m_ready;

    // Occupancy once this cycle's transfer has left.
    assign level = cnt_reg - {1'b0, pop};

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        unique case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    slot0_next = push_item;
                end else begin
                    slot1_next = push_item;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    slot0_next = push_item;
                end else begin
                    slot0_next = slot1_reg;
                    slot1_next = push_item;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: sv/rde_ctrl.sv
module rde_ctrl #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rde_pkg::func_t                     s_func,
    input  logic [rde_pkg::DATA_W-1:0]         s_value,
    output logic                               ram_we,
    output logic [$clog2(DEPTH)-1:0]           ram_waddr,
    output logic [((VALUE_BITS < rde_pkg::DATA_W) ? VALUE_BITS : rde_pkg::DATA_W)-1:0]
                                               ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(DEPTH)-1:0]           ram_raddr,
    input  logic [((VALUE_BITS < rde_pkg::DATA_W) ? VALUE_BITS : rde_pkg::DATA_W)-1:0]
                                               ram_rdata,
    input  logic [1:0]                         q_level,
    output logic                               q_push,
    output rde_pkg::out_item_t                 q_item
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = CW + 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                 state_reg, state_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 rev_reg, rev_next;
    logic                 err_reg, err_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    rde_pkg::kind_t       pend_kind_reg, pend_kind_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 pend_ram_reg, pend_ram_next;

    logic                 accept;
    logic                 issue_ok;
    logic                 drain_last;
    logic [CW-1:0]        drain_off;
    logic                 done;

    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(off);
        if (sum >= SUMW'(DEPTH)) begin
            sum = sum - SUMW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // A read may go out only if the output queue has a slot for it, counting
    // the read that is still in flight.
    assign issue_ok = ({1'b0, q_level} + {2'b00, pend_valid_reg}) < 3'd2;

    assign drain_last = (idx_reg == count_reg - CW'(1));
    assign drain_off  = rev_reg ? (count_reg - CW'(1) - idx_reg) : idx_reg;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        err_next        = err_reg;
        idx_next        = idx_reg;
        pend_valid_next = 1'b0;
        pend_kind_next  = pend_kind_reg;
        pend_last_next  = pend_last_reg;
        pend_ram_next   = pend_ram_reg;
        ram_we          = 1'b0;
        ram_waddr       = ring_pos(head_reg, count_reg);
        ram_wdata       = s_value[$bits(ram_wdata)-1:0];
        ram_re          = 1'b0;
        ram_raddr       = ring_pos(head_reg, drain_off);
        done            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        rde_pkg::FUNC_LOAD: begin
                            if (count_reg == CW'(DEPTH)) begin
                                err_next = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        rde_pkg::FUNC_REVERSE: begin
                            rev_next = !rev_reg;
                        end
                        rde_pkg::FUNC_DELETE: begin
                            if (count_reg == CW'(0)) begin
                                err_next = 1'b1;
                            end else begin
                                if (!rev_reg) begin
                                    head_next = ring_pos(head_reg, CW'(1));
                                end
                                count_next = count_reg - CW'(1);
                            end
                        end
                        rde_pkg::FUNC_FINISH: begin
                            state_next = ST_DRAIN;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (issue_ok) begin
                    pend_valid_next = 1'b1;
                    priority if (err_reg) begin
                        pend_kind_next = rde_pkg::KIND_ERROR;
                        pend_last_next = 1'b1;
                        pend_ram_next  = 1'b0;
                        done           = 1'b1;
                    end else if (count_reg == CW'(0)) begin
                        pend_kind_next = rde_pkg::KIND_EMPTY;
                        pend_last_next = 1'b1;
                        pend_ram_next  = 1'b0;
                        done           = 1'b1;
                    end else begin
                        ram_re         = 1'b1;
                        pend_kind_next = rde_pkg::KIND_VALUE;
                        pend_last_next = drain_last;
                        pend_ram_next  = 1'b1;
                        idx_next       = idx_reg + CW'(1);
                        done           = drain_last;
                    end
                end
                if (done) begin
                    state_next = ST_IDLE;
                    head_next  = '0;
                    count_next = '0;
                    rev_next   = 1'b0;
                    err_next   = 1'b0;
                    idx_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            err_reg        <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rev_reg        <= rev_next;
            err_reg        <= err_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_last_reg <= pend_last_next;
        pend_ram_reg  <= pend_ram_next;
    end

    assign q_push       = pend_valid_reg;
    assign q_item.kind  = pend_kind_reg;
    assign q_item.value = pend_ram_reg ? rde_pkg::DATA_W'(ram_rdata) : '0;
    assign q_item.last  = pend_last_reg;

endmodule

FILE: sv/reversible_deque_engine.sv
// Ring-buffer deque with a direction flag, kept in a single-port-write,
// single-port-read RAM of DEPTH entries. Load, reverse and delete transfers
// are taken whenever the engine is idle. A finish holds the input side until
// its last result (a value, or an error or empty marker) has been issued,
// paced by the one RAM read issued per cycle; output stalls stretch this,
// since reads go out only when the two-entry output queue has room. Results
// drain in the current direction with tlast on the final one. After a finish
// the deque, direction and error are cleared; the RAM needs no clearing pass
// and its unwritten entries are never read.
module reversible_deque_engine #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rde_pkg::DATA_W-1:0] s_tdata,  // [15:0] value
    input  rde_pkg::func_t             s_tuser,  // [1:0] func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rde_pkg::DATA_W-1:0] m_tdata,  // [15:0] value_res
    output rde_pkg::kind_t             m_tuser,  // [1:0] kind
    output logic                       m_tlast
);

    localparam int IW = $clog2(DEPTH);
    localparam int SW = (VALUE_BITS < rde_pkg::DATA_W) ? VALUE_BITS : rde_pkg::DATA_W;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [SW-1:0]      ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [SW-1:0]      ram_rdata;
    logic [1:0]         q_level;
    logic               q_push;
    rde_pkg::out_item_t q_item;
    rde_pkg::out_item_t m_item;

    rde_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    rde_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_func    (s_tuser),
        .s_value   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    rde_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (m_item),
        .level     (q_level)
    );

    assign m_tdata = m_item.value;
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.last;

endmodule

FILE: sv/rde_checker.sv
module rde_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rde_pkg::DATA_W-1:0] m_tdata,
    input rde_pkg::kind_t             m_tuser,
    input logic                       m_tlast
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Error and empty markers are the only result of their finish: each carries tlast and zero data.
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rde_pkg::KIND_ERROR || m_tuser == rde_pkg::KIND_EMPTY)
        |-> m_tlast && (m_tdata == '0))
        else $error("marker result without tlast or with nonzero data");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == rde_pkg::KIND_VALUE || m_tuser == rde_pkg::KIND_ERROR
                      || m_tuser == rde_pkg::KIND_EMPTY))
        else $error("undefined result kind");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (.*);
